### hdl/efb_pkg.sv
// types, constants and the crc-32 byte update for the ethernet frame builder
// no dependencies; used by ethernet_frame_builder_fcs
package efb_pkg;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned ETYPE_W = 16;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DST_MAC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_MAC     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ETHER_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAYLOAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd4;

  // register reset values
  localparam logic [MAC_W-1:0]   DST_MAC_RST     = 48'h0009_7307_7473;
  localparam logic [MAC_W-1:0]   SRC_MAC_RST     = 48'h0009_7307_73F9;
  localparam logic [ETYPE_W-1:0] ETHER_TYPE_RST  = 16'h0800;
  localparam logic [LEN_W-1:0]   MIN_PAYLOAD_RST = 11'd46;
  localparam logic [LEN_W-1:0]   MAX_PAYLOAD_RST = 11'd1500;

  // byte positions within the results of one input word
  localparam logic [POS_W-1:0] POS_DEST_FIRST = 5'd0;
  localparam logic [POS_W-1:0] POS_DEST_LAST  = 5'd5;
  localparam logic [POS_W-1:0] POS_SRC_FIRST  = 5'd6;
  localparam logic [POS_W-1:0] POS_SRC_LAST   = 5'd11;
  localparam logic [POS_W-1:0] POS_ETYPE_HI   = 5'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO   = 5'd13;
  localparam logic [POS_W-1:0] POS_PAYLOAD    = 5'd14;
  localparam logic [POS_W-1:0] POS_FCS_FIRST  = 5'd15;
  localparam logic [POS_W-1:0] POS_FCS_LAST   = 5'd18;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } efb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       length_error;
  } efb_out_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hdl/ethernet_frame_builder_fcs.sv
// ethernet frame builder: header insertion, payload pass-through, crc-32 fcs
// depends on efb_pkg
//
// usage
// - in channel (in_valid/in_ready/in_data): one payload byte per word, last
//   marks the final byte of a frame
// - out channel (out_valid/out_ready/out_data): frame bytes in send order;
//   run_last closes the results of one input word, frame_end marks the last
//   fcs byte and carries length_error
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, write
//   only while the block is idle; unknown indexes are ignored
// - a taken word goes to the hold register, its results to the output register
// - throughput: one output byte per cycle from the single output register
//   while out_ready stays high; a middle payload word gives 1 byte, the first
//   word of a frame 15 (14 header bytes + payload), a last one 4 fcs bytes more
// - a new word is taken in the cycle the current one emits its final byte
// - reset: registers return to their defaults, no frame open, crc all ones
// - receiver stall: the output register holds, the current word holds and
//   in_ready drops once that word is waiting
module ethernet_frame_builder_fcs #(
  parameter int unsigned COUNT_MAX = 2047
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  efb_pkg::efb_in_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output efb_pkg::efb_out_t        out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [47:0]              cfg_data
);

  import efb_pkg::*;

  localparam int unsigned CNT_W = $clog2(COUNT_MAX + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_MAX);

  logic [MAC_W-1:0]   dst_mac_r, src_mac_r;
  logic [ETYPE_W-1:0] ether_type_r;
  logic [LEN_W-1:0]   min_payload_r, max_payload_r;

  logic            hold_valid_r;
  efb_in_t         hold_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic            in_frame_r, in_frame_nxt;
  logic [31:0]     crc_r, crc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            out_valid_r;
  efb_out_t        out_data_r, out_nxt;

  logic            emit, done, accept;
  logic [2:0]      mac_k;
  logic [MAC_W-1:0] mac_sh;
  logic [31:0]     fcs, fcs_sh;
  logic [7:0]      byte_sel;
  logic            len_err;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_mac_r     <= DST_MAC_RST;
      src_mac_r     <= SRC_MAC_RST;
      ether_type_r  <= ETHER_TYPE_RST;
      min_payload_r <= MIN_PAYLOAD_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DST_MAC:     dst_mac_r     <= cfg_data;
        REG_SRC_MAC:     src_mac_r     <= cfg_data;
        REG_ETHER_TYPE:  ether_type_r  <= cfg_data[ETYPE_W-1:0];
        REG_MIN_PAYLOAD: min_payload_r <= cfg_data[LEN_W-1:0];
        REG_MAX_PAYLOAD: max_payload_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign emit     = hold_valid_r && (!out_valid_r || out_ready);
  assign done     = emit && ((pos_r == POS_PAYLOAD && !hold_r.last) || pos_r == POS_FCS_LAST);
  assign in_ready = !hold_valid_r || done;
  assign accept   = in_valid && in_ready;

  assign fcs     = ~crc_r;
  assign fcs_sh  = fcs >> {2'(pos_r - POS_FCS_FIRST), 3'b000};
  assign len_err = (CNT_W'(min_payload_r) > count_r) ||
                   (CNT_W'(max_payload_r) < count_r);

  always_comb begin
    mac_k    = '0;
    mac_sh   = '0;
    byte_sel = hold_r.data_byte;
    case (pos_r) inside
      [POS_DEST_FIRST:POS_DEST_LAST]: begin
        mac_k    = 3'(POS_DEST_LAST - pos_r);
        mac_sh   = dst_mac_r >> {mac_k, 3'b000};
        byte_sel = mac_sh[7:0];
      end
      [POS_SRC_FIRST:POS_SRC_LAST]: begin
        mac_k    = 3'(POS_SRC_LAST - pos_r);
        mac_sh   = src_mac_r >> {mac_k, 3'b000};
        byte_sel = mac_sh[7:0];
      end
      POS_ETYPE_HI: byte_sel = ether_type_r[15:8];
      POS_ETYPE_LO: byte_sel = ether_type_r[7:0];
      POS_PAYLOAD:  byte_sel = hold_r.data_byte;
      [POS_FCS_FIRST:POS_FCS_LAST]: byte_sel = fcs_sh[7:0];
      default: byte_sel = hold_r.data_byte;
    endcase
  end

  always_comb begin
    out_nxt              = '0;
    out_nxt.out_byte     = byte_sel;
    out_nxt.run_last     = done;
    out_nxt.frame_end    = (pos_r == POS_FCS_LAST);
    out_nxt.length_error = (pos_r == POS_FCS_LAST) && len_err;

    crc_nxt      = crc_r;
    count_nxt    = count_r;
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    if (emit) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r <= POS_PAYLOAD) begin
        crc_nxt      = crc_byte(crc_r, byte_sel);
        in_frame_nxt = 1'b1;
      end
      if (pos_r == POS_PAYLOAD && count_r < CNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
      if (pos_r == POS_FCS_LAST) begin
        crc_nxt      = CRC_INIT;
        count_nxt    = '0;
        in_frame_nxt = 1'b0;
      end
    end
    if (accept) begin
      pos_nxt = in_frame_nxt ? POS_PAYLOAD : POS_DEST_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      pos_r        <= POS_DEST_FIRST;
      in_frame_r   <= 1'b0;
      crc_r        <= CRC_INIT;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= accept || (hold_valid_r && !done);
      pos_r        <= pos_nxt;
      in_frame_r   <= in_frame_nxt;
      crc_r        <= crc_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= emit || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_data;
    end
    if (emit) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> pos_r <= POS_FCS_LAST)
    else $error("position past end of fcs");

  a_frame_end_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_end |-> out_data_r.run_last)
    else $error("frame end without run last");

  a_lerr_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.length_error |-> out_data_r.frame_end)
    else $error("length error outside frame end");

  a_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit && pos_r == POS_FCS_LAST |=> crc_r == CRC_INIT && count_r == '0 && !in_frame_r)
    else $error("frame state not cleared after fcs");

  a_header_only_new_frame: assert property (@(posedge clk) disable iff (!rst_n)
    emit && pos_r == POS_DEST_FIRST |-> !in_frame_r && crc_r == CRC_INIT)
    else $error("header started inside a frame");

endmodule
